// ===== sv/rs_pkg.sv =====
// Shared types and constants for the rectangle subtract block.
package rs_pkg;

    // Coordinate width of every rectangle edge
    localparam int COORD_W = 16;

    // Depth of the job queue between classifier and piece emitter
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Piece kind codes
    localparam logic [2:0] KIND_TOP    = 3'd0;
    localparam logic [2:0] KIND_BOTTOM = 3'd1;
    localparam logic [2:0] KIND_LEFT   = 3'd2;
    localparam logic [2:0] KIND_RIGHT  = 3'd3;
    localparam logic [2:0] KIND_WHOLE  = 3'd4;

    // Inclusive rectangle
    typedef struct packed {
        logic signed [COORD_W-1:0] left;
        logic signed [COORD_W-1:0] top;
        logic signed [COORD_W-1:0] right;
        logic signed [COORD_W-1:0] bottom;
    } rect_t;

    // Classified job: mask bit order is top, bottom, left, right.
    // whole set: emit original as is; mask zero and whole clear: empty marker.
    typedef struct packed {
        rect_t      orig;
        rect_t      ovl;
        logic [3:0] mask;
        logic       whole;
    } job_t;

endpackage

// ===== sv/rs_front.sv =====
// Front end: accepts a rectangle pair, computes the overlap and classifies the job.
module rs_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  rs_pkg::rect_t in_orig,
    input  rs_pkg::rect_t in_cut,
    output logic          job_valid,
    input  logic          job_ready,
    output rs_pkg::job_t  job
);
    import rs_pkg::*;

    rect_t      ovl;
    logic       orig_ok;
    logic       ovl_ok;
    logic [3:0] side_mask;
    job_t       job_next;
    logic       job_valid_reg;
    job_t       job_reg;

    // Overlap rectangle
    always_comb
    begin
        ovl.left   = (in_orig.left   > in_cut.left)   ? in_orig.left   : in_cut.left;
        ovl.top    = (in_orig.top    > in_cut.top)    ? in_orig.top    : in_cut.top;
        ovl.right  = (in_orig.right  < in_cut.right)  ? in_orig.right  : in_cut.right;
        ovl.bottom = (in_orig.bottom < in_cut.bottom) ? in_orig.bottom : in_cut.bottom;
    end

    // Validity and non-empty pieces; overlap lies inside the original when valid
    always_comb
    begin
        orig_ok      = (in_orig.left <= in_orig.right) && (in_orig.top <= in_orig.bottom);
        ovl_ok       = (ovl.left <= ovl.right) && (ovl.top <= ovl.bottom);
        side_mask[0] = ovl.top    > in_orig.top;
        side_mask[1] = ovl.bottom < in_orig.bottom;
        side_mask[2] = ovl.left   > in_orig.left;
        side_mask[3] = ovl.right  < in_orig.right;

        job_next.orig  = in_orig;
        job_next.ovl   = ovl;
        job_next.whole = orig_ok && !ovl_ok;
        job_next.mask  = (orig_ok && ovl_ok) ? side_mask : 4'b0000;
    end

    assign in_ready = !job_valid_reg || job_ready;

    // Stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            job_valid_reg <= in_valid;
        end
    end

    // Stage payload
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            job_reg <= job_next;
        end
    end

    assign job_valid = job_valid_reg;
    assign job       = job_reg;

endmodule

// ===== sv/rs_fifo.sv =====
// Short first-word-fall-through job queue between front and back ends.
module rs_fifo (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         wr_valid,
    output logic         wr_ready,
    input  rs_pkg::job_t wr_data,
    output logic         rd_valid,
    input  logic         rd_pop,
    output rs_pkg::job_t rd_data
);
    import rs_pkg::*;

    job_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_wr;
    logic              do_rd;

    assign wr_ready = (count_reg != QCNT_W'(QDEPTH));
    assign rd_valid = (count_reg != '0);
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_pop && rd_valid;
    assign rd_data  = mem_reg[rd_ptr_reg];

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== sv/rs_back.sv =====
// Back end: walks the pieces of the head job and drives the output register.
module rs_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          job_valid,
    output logic          job_pop,
    input  rs_pkg::job_t  job,
    output logic          out_valid,
    input  logic          out_ready,
    output rs_pkg::rect_t out_piece,
    output logic [2:0]    out_kind,
    output logic          out_present,
    output logic          out_last
);
    import rs_pkg::*;

    logic [3:0] rem_reg;
    logic [3:0] pend;
    logic [3:0] pick;
    logic [2:0] pick_kind;
    logic [2:0] sel_kind;
    rect_t      sel_piece;
    logic       sel_present;
    logic       sel_last;
    logic       load;
    logic       out_valid_reg;
    rect_t      piece_reg;
    logic [2:0] kind_reg;
    logic       present_reg;
    logic       last_reg;

    assign pend = job.mask & rem_reg;

    // Lowest pending piece in top, bottom, left, right order
    always_comb
    begin
        pick      = 4'b0000;
        pick_kind = KIND_TOP;
        if (pend[0])
        begin
            pick      = 4'b0001;
            pick_kind = KIND_TOP;
        end
        else if (pend[1])
        begin
            pick      = 4'b0010;
            pick_kind = KIND_BOTTOM;
        end
        else if (pend[2])
        begin
            pick      = 4'b0100;
            pick_kind = KIND_LEFT;
        end
        else if (pend[3])
        begin
            pick      = 4'b1000;
            pick_kind = KIND_RIGHT;
        end
    end

    // Piece geometry and flags
    always_comb
    begin
        sel_piece   = '0;
        sel_kind    = pick_kind;
        sel_present = 1'b0;
        sel_last    = 1'b1;
        if (job.whole)
        begin
            sel_piece   = job.orig;
            sel_kind    = KIND_WHOLE;
            sel_present = 1'b1;
        end
        else if (pend != 4'b0000)
        begin
            sel_present = 1'b1;
            sel_last    = ((pend & ~pick) == 4'b0000);
            case (pick_kind)
                KIND_TOP:
                begin
                    sel_piece        = job.orig;
                    sel_piece.bottom = job.ovl.top - 16'sd1;
                end
                KIND_BOTTOM:
                begin
                    sel_piece     = job.orig;
                    sel_piece.top = job.ovl.bottom + 16'sd1;
                end
                KIND_LEFT:
                begin
                    sel_piece.left   = job.orig.left;
                    sel_piece.top    = job.ovl.top;
                    sel_piece.right  = job.ovl.left - 16'sd1;
                    sel_piece.bottom = job.ovl.bottom;
                end
                KIND_RIGHT:
                begin
                    sel_piece.left   = job.ovl.right + 16'sd1;
                    sel_piece.top    = job.ovl.top;
                    sel_piece.right  = job.orig.right;
                    sel_piece.bottom = job.ovl.bottom;
                end
                default:
                begin
                    sel_piece = '0;
                end
            endcase
        end
        else
        begin
            sel_kind = KIND_TOP;
        end
    end

    assign load    = job_valid && (!out_valid_reg || out_ready);
    assign job_pop = load && sel_last;

    // Control: pending mask of head job and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg       <= 4'b1111;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (job_pop)
            begin
                rem_reg <= 4'b1111;
            end
            else if (load)
            begin
                rem_reg <= rem_reg & ~pick;
            end
            if (!out_valid_reg || out_ready)
            begin
                out_valid_reg <= job_valid;
            end
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            piece_reg   <= sel_piece;
            kind_reg    <= sel_kind;
            present_reg <= sel_present;
            last_reg    <= sel_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_piece   = piece_reg;
    assign out_kind    = kind_reg;
    assign out_present = present_reg;
    assign out_last    = last_reg;

endmodule

// ===== sv/rectangle_subtract.sv =====
// Rectangle subtract: emits the pieces of an original rectangle outside a cut rectangle.
// Path to the first result: front register, job queue, output register of the emitter.
// Throughput: one result per cycle unless the output stalls; an item gives 1 to 4 results,
//   all sent through the single output register of the piece emitter.
// Input transfers continue while results wait, until the two-entry job queue fills.
// Reset: rst_n asynchronous active low; clears all valids and the queue, no output pending.
module rectangle_subtract (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // orig_left, orig_top, orig_right, orig_bottom, cut_left, cut_top, cut_right, cut_bottom
    input  logic [127:0]  s_axis_tdata,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // piece_left, piece_top, piece_right, piece_bottom
    output logic [63:0]   m_axis_tdata,
    // piece_kind[2:0], piece_present[3]
    output logic [3:0]    m_axis_tuser,
    // last_piece
    output logic          m_axis_tlast
);
    import rs_pkg::*;

    rect_t      in_orig;
    rect_t      in_cut;
    logic       fr_valid;
    logic       fr_ready;
    job_t       fr_job;
    logic       q_valid;
    logic       q_pop;
    job_t       q_job;
    rect_t      out_piece;
    logic [2:0] out_kind;
    logic       out_present;

    // Unpack input transfer
    always_comb
    begin
        in_orig.left   = s_axis_tdata[15:0];
        in_orig.top    = s_axis_tdata[31:16];
        in_orig.right  = s_axis_tdata[47:32];
        in_orig.bottom = s_axis_tdata[63:48];
        in_cut.left    = s_axis_tdata[79:64];
        in_cut.top     = s_axis_tdata[95:80];
        in_cut.right   = s_axis_tdata[111:96];
        in_cut.bottom  = s_axis_tdata[127:112];
    end

    rs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_orig   (in_orig),
        .in_cut    (in_cut),
        .job_valid (fr_valid),
        .job_ready (fr_ready),
        .job       (fr_job)
    );

    rs_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fr_valid),
        .wr_ready (fr_ready),
        .wr_data  (fr_job),
        .rd_valid (q_valid),
        .rd_pop   (q_pop),
        .rd_data  (q_job)
    );

    rs_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .job_valid   (q_valid),
        .job_pop     (q_pop),
        .job         (q_job),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_piece   (out_piece),
        .out_kind    (out_kind),
        .out_present (out_present),
        .out_last    (m_axis_tlast)
    );

    // Pack output transfer
    assign m_axis_tdata = {out_piece.bottom, out_piece.right, out_piece.top, out_piece.left};
    assign m_axis_tuser = {out_present, out_kind};

endmodule

// ===== sv/rs_checker.sv =====
// Port-level assertions for rectangle_subtract and their bind.
module rs_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [63:0]  m_axis_tdata,
    input logic [3:0]   m_axis_tuser,
    input logic         m_axis_tlast
);
    import rs_pkg::*;

    logic signed [15:0] p_left;
    logic signed [15:0] p_top;
    logic signed [15:0] p_right;
    logic signed [15:0] p_bottom;

    assign p_left   = m_axis_tdata[15:0];
    assign p_top    = m_axis_tdata[31:16];
    assign p_right  = m_axis_tdata[47:32];
    assign p_bottom = m_axis_tdata[63:48];

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    // Empty marker is all zero and closes the item
    a_empty_marker: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[3] |->
            m_axis_tdata == 64'd0 && m_axis_tuser[2:0] == KIND_TOP && m_axis_tlast)
        else $error("malformed empty marker");

    // Whole original is a single result
    a_whole_single: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[2:0] == KIND_WHOLE |-> m_axis_tlast && m_axis_tuser[3])
        else $error("whole original not a single carried result");

    // A carried piece is a valid rectangle
    a_piece_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[3] |-> p_left <= p_right && p_top <= p_bottom)
        else $error("carried piece is empty");

endmodule

bind rectangle_subtract rs_checker u_rs_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

// ===== tb/rect_sub_checker.sv =====
// Checker for rectangle_subtract: predicts the pieces of each input transfer and compares results.
`timescale 1ns / 100ps
module rect_sub_checker (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    // orig_left, orig_top, orig_right, orig_bottom, cut_left, cut_top, cut_right, cut_bottom
    input  logic [127:0] s_axis_tdata,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // piece_left, piece_top, piece_right, piece_bottom
    input  logic [63:0]  m_axis_tdata,
    // piece_kind[2:0], piece_present[3]
    input  logic [3:0]   m_axis_tuser,
    // last_piece
    input  logic         m_axis_tlast,
    output int           fails,
    output int           pending
);

    localparam int CW = rs_pkg::COORD_W;

    // empty marker reports kind zero
    localparam logic [2:0] KIND_NONE = rs_pkg::KIND_TOP;

    // edge value with one guard bit, so edge -/+ 1 never wraps
    typedef logic signed [CW:0] wide_t;

    typedef struct {
        logic signed [CW-1:0] left;
        logic signed [CW-1:0] top;
        logic signed [CW-1:0] right;
        logic signed [CW-1:0] bottom;
        logic [2:0]           kind;
        logic                 present;
        logic                 last;
    } piece_t;

    piece_t piece_q[$];
    int     err_count = 0;
    int     queued = 0;

    assign fails   = err_count;
    assign pending = queued;

    function automatic wide_t widen(input logic [CW-1:0] v);
        return {v[CW-1], v};
    endfunction

    function automatic void push_piece(input wide_t l, input wide_t t, input wide_t r,
                                       input wide_t b, input logic [2:0] kind,
                                       input logic present, input logic last);
        piece_t p;
        p.left    = l[CW-1:0];
        p.top     = t[CW-1:0];
        p.right   = r[CW-1:0];
        p.bottom  = b[CW-1:0];
        p.kind    = kind;
        p.present = present;
        p.last    = last;
        piece_q.insert(piece_q.size(), p);
    endfunction

    // Work out the pieces left over when the cut is removed from the original
    function automatic void predict_pieces(input logic [127:0] d);
        wide_t      org_l, org_t, org_r, org_b;
        wide_t      cut_l, cut_t, cut_r, cut_b;
        wide_t      ov_l, ov_t, ov_r, ov_b;
        wide_t      pl[4], pt[4], pr[4], pb[4];
        logic [2:0] kinds[4];
        int         last_k;
        org_l = widen(d[15:0]);
        org_t = widen(d[31:16]);
        org_r = widen(d[47:32]);
        org_b = widen(d[63:48]);
        cut_l = widen(d[79:64]);
        cut_t = widen(d[95:80]);
        cut_r = widen(d[111:96]);
        cut_b = widen(d[127:112]);

        ov_l = (org_l > cut_l) ? org_l : cut_l;
        ov_t = (org_t > cut_t) ? org_t : cut_t;
        ov_r = (org_r < cut_r) ? org_r : cut_r;
        ov_b = (org_b < cut_b) ? org_b : cut_b;

        if (org_l > org_r || org_t > org_b) begin
            // original is not a rectangle
            push_piece('0, '0, '0, '0, KIND_NONE, 1'b0, 1'b1);
        end
        else if (ov_l > ov_r || ov_t > ov_b) begin
            // nothing overlaps: original goes out untouched
            push_piece(org_l, org_t, org_r, org_b, rs_pkg::KIND_WHOLE, 1'b1, 1'b1);
        end
        else if (ov_l == org_l && ov_t == org_t && ov_r == org_r && ov_b == org_b) begin
            // cut covers all of it
            push_piece('0, '0, '0, '0, KIND_NONE, 1'b0, 1'b1);
        end
        else begin
            // top and bottom span full width, left and right only the overlap rows
            kinds[0] = rs_pkg::KIND_TOP;
            kinds[1] = rs_pkg::KIND_BOTTOM;
            kinds[2] = rs_pkg::KIND_LEFT;
            kinds[3] = rs_pkg::KIND_RIGHT;
            pl[0] = org_l;
            pt[0] = org_t;
            pr[0] = org_r;
            pb[0] = ov_t - wide_t'(1);
            pl[1] = org_l;
            pt[1] = ov_b + wide_t'(1);
            pr[1] = org_r;
            pb[1] = org_b;
            pl[2] = org_l;
            pt[2] = ov_t;
            pr[2] = ov_l - wide_t'(1);
            pb[2] = ov_b;
            pl[3] = ov_r + wide_t'(1);
            pt[3] = ov_t;
            pr[3] = org_r;
            pb[3] = ov_b;
            last_k = -1;
            for (int k = 0; k < 4; k++) begin
                if (pl[k] <= pr[k] && pt[k] <= pb[k])
                    last_k = k;
            end
            for (int k = 0; k < 4; k++) begin
                if (pl[k] <= pr[k] && pt[k] <= pb[k])
                    push_piece(pl[k], pt[k], pr[k], pb[k], kinds[k], 1'b1, k == last_k);
            end
            if (last_k < 0)
                push_piece('0, '0, '0, '0, KIND_NONE, 1'b0, 1'b1);
        end
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            err_count++;
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    // Sample both channels at the rising edge
    always @(posedge clk) begin : watch
        piece_t want;
        if (rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                predict_pieces(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready) begin
                if (piece_q.size() == 0) begin
                    err_count++;
                    $display("%0t ns: unexpected result, expected none, got %h/%h/%b",
                             $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
                end
                else begin
                    want = piece_q.pop_front();
                    check_field("piece_left", want.left, $signed(m_axis_tdata[15:0]));
                    check_field("piece_top", want.top, $signed(m_axis_tdata[31:16]));
                    check_field("piece_right", want.right, $signed(m_axis_tdata[47:32]));
                    check_field("piece_bottom", want.bottom, $signed(m_axis_tdata[63:48]));
                    check_field("piece_kind", want.kind, m_axis_tuser[2:0]);
                    check_field("piece_present", want.present, m_axis_tuser[3]);
                    check_field("last_piece", want.last, m_axis_tlast);
                end
            end
            queued = piece_q.size();
        end
    end

endmodule

// ===== tb/tb_rectangle_subtract.sv =====
// Testbench top for rectangle_subtract: clock, reset, stimulus, output stalls and verdict.
`timescale 1ns / 100ps
module tb_rectangle_subtract;

    localparam int RANDOM_ITEMS = 350;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [63:0]  m_axis_tdata;
    logic [3:0]   m_axis_tuser;
    logic         m_axis_tlast;

    int fails;
    int pending;
    bit tx_calm = 1'b0;
    bit rx_calm = 1'b0;
    int rx_hold = 0;

    rectangle_subtract dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    rect_sub_checker u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .fails         (fails),
        .pending       (pending)
    );

    always #6 clk = ~clk;

    // Run limit, far above the slowest legal run
    initial
    begin
        #10_000_000;
        $display("tb_rectangle_subtract: errors");
        $finish;
    end

    // Output stalls: mostly short, a few long, with calm stretches of no stall
    always @(negedge clk) begin : sink
        int r;
        if ($urandom_range(0, 63) == 0)
            rx_calm <= !rx_calm;
        if (rx_hold > 0) begin
            m_axis_tready <= 1'b0;
            rx_hold       <= rx_hold - 1;
        end
        else if (rx_calm) begin
            m_axis_tready <= 1'b1;
        end
        else begin
            r = $urandom_range(0, 99);
            if (r < 65) begin
                m_axis_tready <= 1'b1;
            end
            else begin
                m_axis_tready <= 1'b0;
                rx_hold       <= (r < 92) ? $urandom_range(0, 2) : $urandom_range(8, 30);
            end
        end
    end

    function automatic int sat16(input int v);
        return (v < -32768) ? -32768 : ((v > 32767) ? 32767 : v);
    endfunction

    function automatic int any16();
        logic signed [15:0] u;
        u = 16'($urandom);
        return int'(u);
    endfunction

    // Edges near both ends of the range show up often
    function automatic int edge_coord();
        int r;
        r = $urandom_range(0, 3);
        if (r == 0)
            return -32768 + int'($urandom_range(0, 8));
        else if (r == 1)
            return 32767 - int'($urandom_range(0, 8));
        else
            return any16();
    endfunction

    function automatic logic [127:0] pack_item(input int o_l, input int o_t, input int o_r,
                                               input int o_b, input int c_l, input int c_t,
                                               input int c_r, input int c_b);
        return {c_b[15:0], c_r[15:0], c_t[15:0], c_l[15:0],
                o_b[15:0], o_r[15:0], o_t[15:0], o_l[15:0]};
    endfunction

    // Mostly a valid original with a cut close to it; some noise
    function automatic logic [127:0] random_item();
        int o_l, o_t, o_r, o_b, c_l, c_t, c_r, c_b, w, h, r, x;
        r = $urandom_range(0, 19);
        if (r < 2) begin
            o_l = any16(); o_t = any16(); o_r = any16(); o_b = any16();
            c_l = any16(); c_t = any16(); c_r = any16(); c_b = any16();
        end
        else if (r == 2) begin
            o_l = any16(); o_t = any16(); o_r = any16(); o_b = any16();
            if (o_l > o_r) begin x = o_l; o_l = o_r; o_r = x; end
            if (o_t > o_b) begin x = o_t; o_t = o_b; o_b = x; end
            c_l = any16(); c_t = any16(); c_r = any16(); c_b = any16();
        end
        else begin
            o_l = edge_coord();
            o_t = edge_coord();
            w   = $urandom_range(0, 12);
            h   = $urandom_range(0, 12);
            o_r = sat16(o_l + w);
            o_b = sat16(o_t + h);
            c_l = sat16(o_l - 3 + int'($urandom_range(0, w + 6)));
            c_t = sat16(o_t - 3 + int'($urandom_range(0, h + 6)));
            c_r = sat16(c_l + int'($urandom_range(0, w + 3)));
            c_b = sat16(c_t + int'($urandom_range(0, h + 3)));
        end
        return pack_item(o_l, o_t, o_r, o_b, c_l, c_t, c_r, c_b);
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (tx_calm || r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    // One input transfer; called and returns at a falling edge
    task automatic send_item(input logic [127:0] item);
        int gap;
        if ($urandom_range(0, 39) == 0)
            tx_calm = !tx_calm;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= item;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    initial
    begin
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // original not a rectangle, each way
        send_item(pack_item(10, 0, 5, 5, 0, 0, 3, 3));
        send_item(pack_item(0, 10, 5, 5, 0, 0, 3, 3));
        // no overlap, then a cut that is not a rectangle
        send_item(pack_item(0, 0, 9, 9, 20, 0, 30, 9));
        send_item(pack_item(0, 0, 9, 9, 5, 5, 2, 2));
        // fully covered: same rectangle and a larger one
        send_item(pack_item(0, 0, 9, 9, 0, 0, 9, 9));
        send_item(pack_item(0, 0, 9, 9, -5, -5, 20, 20));
        // cut inside: all four pieces
        send_item(pack_item(0, 0, 9, 9, 3, 3, 6, 6));
        // one piece left: top, bottom, left, right
        send_item(pack_item(0, 0, 9, 9, -1, 5, 10, 12));
        send_item(pack_item(0, 0, 9, 9, -1, -1, 10, 4));
        send_item(pack_item(0, 0, 9, 9, 5, -1, 10, 10));
        send_item(pack_item(0, 0, 9, 9, -1, -1, 4, 10));
        // corner overlap, and a single touching column
        send_item(pack_item(0, 0, 9, 9, 5, 5, 15, 15));
        send_item(pack_item(0, 0, 9, 9, 9, -5, 20, 20));
        // full range original against full range, min and max corner points
        send_item(pack_item(-32768, -32768, 32767, 32767, -32768, -32768, 32767, 32767));
        send_item(pack_item(-32768, -32768, 32767, 32767, -32768, -32768, -32768, -32768));
        send_item(pack_item(-32768, -32768, 32767, 32767, 32767, 32767, 32767, 32767));
        send_item(pack_item(-32768, -32768, 32767, 32767, -100, -32768, 100, 32767));
        // small rectangles at the range ends
        send_item(pack_item(-32768, -32768, -32767, -32767, -32768, -32768, -32768, -32768));
        send_item(pack_item(32766, 32766, 32767, 32767, 32767, 32767, 32767, 32767));
        // single point original: covered, then missed
        send_item(pack_item(7, 7, 7, 7, 7, 7, 7, 7));
        send_item(pack_item(7, 7, 7, 7, 8, 7, 9, 7));
        // all-ones against all-zeros patterns
        send_item(pack_item(-1, -1, 0, 0, 0, 0, 0, 0));

        for (int i = 0; i < RANDOM_ITEMS; i++)
            send_item(random_item());
        s_axis_tvalid <= 1'b0;

        // drain, then keep sampling the output to catch stray results
        while (pending != 0)
            @(negedge clk);
        repeat (12) @(negedge clk);

        if (fails == 0)
            $display("tb_rectangle_subtract: clean");
        else
            $display("tb_rectangle_subtract: errors");
        $finish;
    end

endmodule
